FILE: rtl/vdlr_pkg.sv
package vdlr_pkg;

  localparam logic [2:0] OP_MOVE   = 3'd0;
  localparam logic [2:0] OP_COLOUR = 3'd1;
  localparam logic [2:0] OP_DRAW   = 3'd2;
  localparam logic [2:0] OP_FADE   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;
  localparam logic [2:0] OP_READ   = 3'd5;

  localparam logic [15:0] COLOUR_FULL = 16'hFFFF;
  localparam logic [31:0] WORD_WHITE  = 32'hFFFF_FFFF;
  localparam logic [31:0] WORD_RED    = 32'hFFFF_0000;
  localparam logic [7:0]  FADE_STEP   = 8'd8;

  typedef struct packed {
    logic accept;
    logic setup;
    logic step;
    logic clear;
    logic fade_rd;
    logic rd_px;
    logic emit;
  } vdlr_cmd_t;

  typedef struct packed {
    logic line_last;
    logic sweep_last;
    logic draw_on;
    logic fade_on;
  } vdlr_status_t;

endpackage

FILE: rtl/vdlr_ctrl.sv
module vdlr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [2:0]            in_op,
  input  vdlr_pkg::vdlr_status_t st,
  output vdlr_pkg::vdlr_cmd_t    cmd,
  output logic                  busy,
  output logic                  out_valid
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SETUP, S_LINE, S_FADE, S_DRAIN, S_RD, S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r;
  logic   acc_w;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign acc_w     = start && (state_r == S_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.accept  = acc_w;
    cmd.setup   = (state_r == S_SETUP);
    cmd.step    = (state_r == S_LINE);
    cmd.clear   = (state_r == S_CLEAR);
    cmd.fade_rd = (state_r == S_FADE);
    cmd.rd_px   = (state_r == S_RD);
    cmd.emit    = (state_r == S_EMIT);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (st.sweep_last) state_nxt = S_IDLE;
      S_IDLE: begin
        if (acc_w) begin
          if (in_op == vdlr_pkg::OP_MOVE && st.draw_on) state_nxt = S_SETUP;
          else if (in_op == vdlr_pkg::OP_TICK && st.fade_on) state_nxt = S_FADE;
          else if (in_op == vdlr_pkg::OP_READ) state_nxt = S_RD;
          else state_nxt = S_EMIT;
        end
      end
      S_SETUP: state_nxt = S_LINE;
      S_LINE:  if (st.line_last) state_nxt = S_EMIT;
      S_FADE:  if (st.sweep_last) state_nxt = S_DRAIN;
      S_DRAIN: state_nxt = S_EMIT;
      S_RD:    state_nxt = S_EMIT;
      S_EMIT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_r == S_EMIT);
    end
  end

`ifndef SYNTHESIS
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc_w |=> busy) else $error("accept did not raise busy");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r) else $error("result strobe longer than one cycle");
  a_line_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINE && !st.line_last) |=> state_r == S_LINE)
    else $error("line ended early");
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !busy) else $error("result while busy");
`endif

endmodule

FILE: rtl/vdlr_dp.sv
module vdlr_dp #(
  parameter int DISPLAY_SIZE = 256
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  vdlr_pkg::vdlr_cmd_t    cmd,
  output vdlr_pkg::vdlr_status_t st,
  input  logic [2:0]             in_op,
  input  logic [15:0]            in_x,
  input  logic [15:0]            in_y,
  input  logic                   in_colour_mode,
  input  logic [15:0]            in_colour_value,
  input  logic                   in_draw_enable,
  input  logic                   in_fade_on,
  input  logic [15:0]            in_pixel_addr,
  output logic [31:0]            out_read_data,
  output logic [15:0]            out_cursor_x,
  output logic [15:0]            out_cursor_y,
  output logic                   out_fade_active
);

  localparam int PIX = DISPLAY_SIZE * DISPLAY_SIZE;
  localparam int AW  = $clog2(PIX);
  localparam int CW  = $clog2(DISPLAY_SIZE);
  localparam int SW  = CW + 3;

  logic [31:0] mem [PIX];

  logic [15:0] cur_x_r, cur_y_r, colour_r, addr_r;
  logic        draw_r, mode_r, fade_r, rd_ok_r;
  logic [2:0]  op_r;
  logic [CW-1:0] sx0_r, sy0_r, sx1_r, sy1_r;
  logic [CW-1:0] col_r, end_r, row_r;
  logic signed [SW-1:0] acc_r, dx_r, step2_r;
  logic        steep_r, ydir_r;
  logic [31:0] lword_r, q_r;
  logic        lw_r, fv_r;
  logic [AW-1:0] la_r, fa_r, sw_r, raddr;
  logic        sweep_last;

  function automatic logic [CW-1:0] to_screen(input logic [15:0] v);
    logic [31:0] p;
    p = 32'(v) * 32'(DISPLAY_SIZE);
    return CW'(p >> 16);
  endfunction

  function automatic logic [31:0] fade_word(input logic [31:0] w);
    logic [31:0] o;
    o = '0;
    for (int k = 0; k < 4; k++) begin
      if (w[8*k +: 8] > vdlr_pkg::FADE_STEP)
        o[8*k +: 8] = w[8*k +: 8] - vdlr_pkg::FADE_STEP;
    end
    return o;
  endfunction

  // line setup
  logic signed [SW-1:0] x0, y0, x1, y1, ax, ay, a0, b0, a1, b1, dxs, dys, t;
  logic steep;
  always_comb begin
    t  = '0;
    x0 = $signed({3'b000, sx0_r});
    y0 = $signed({3'b000, sy0_r});
    x1 = $signed({3'b000, sx1_r});
    y1 = $signed({3'b000, sy1_r});
    ax = (x0 > x1) ? x0 - x1 : x1 - x0;
    ay = (y0 > y1) ? y0 - y1 : y1 - y0;
    steep = ax < ay;
    a0 = steep ? y0 : x0;
    b0 = steep ? x0 : y0;
    a1 = steep ? y1 : x1;
    b1 = steep ? x1 : y1;
    if (a0 > a1) begin
      t = a0; a0 = a1; a1 = t;
      t = b0; b0 = b1; b1 = t;
    end
    dxs = a1 - a0;
    dys = b1 - b0;
  end

  // line step
  logic [CW-1:0] px, py;
  logic signed [SW-1:0] acc_n;
  always_comb begin
    px    = steep_r ? row_r : col_r;
    py    = steep_r ? col_r : row_r;
    acc_n = acc_r + step2_r;
  end

  assign sweep_last   = (32'(sw_r) == 32'(PIX - 1));
  assign st.line_last  = (col_r == end_r);
  assign st.sweep_last = sweep_last;
  assign st.draw_on    = draw_r;
  assign st.fade_on    = fade_r;
  assign raddr = cmd.rd_px ? AW'(addr_r) : sw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r  <= '0;
      cur_y_r  <= '0;
      draw_r   <= 1'b1;
      mode_r   <= 1'b0;
      colour_r <= vdlr_pkg::COLOUR_FULL;
      fade_r   <= 1'b0;
      sw_r     <= '0;
      lw_r     <= 1'b0;
      fv_r     <= 1'b0;
    end else begin
      lw_r <= cmd.step;
      fv_r <= cmd.fade_rd;
      if (cmd.clear || cmd.fade_rd) sw_r <= sweep_last ? '0 : sw_r + AW'(1);
      if (cmd.accept) begin
        unique case (in_op)
          vdlr_pkg::OP_MOVE: begin
            cur_x_r <= in_x;
            cur_y_r <= in_y;
          end
          vdlr_pkg::OP_COLOUR: begin
            mode_r   <= in_colour_mode;
            colour_r <= in_colour_value;
          end
          vdlr_pkg::OP_DRAW: draw_r <= in_draw_enable;
          vdlr_pkg::OP_FADE: fade_r <= in_fade_on;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= in_op;
      addr_r  <= in_pixel_addr;
      rd_ok_r <= (32'(in_pixel_addr) < 32'(PIX));
      sx0_r   <= to_screen(cur_x_r);
      sy0_r   <= to_screen(cur_y_r);
      sx1_r   <= to_screen(in_x);
      sy1_r   <= to_screen(in_y);
    end
    if (cmd.setup) begin
      steep_r <= steep;
      col_r   <= CW'(a0);
      end_r   <= CW'(a1);
      row_r   <= CW'(b0);
      dx_r    <= dxs;
      step2_r <= ((dys < 0) ? -dys : dys) <<< 1;
      ydir_r  <= b1 > b0;
      acc_r   <= '0;
      if (!mode_r)
        lword_r <= (colour_r == vdlr_pkg::COLOUR_FULL) ? vdlr_pkg::WORD_WHITE : '0;
      else
        lword_r <= (colour_r == '0) ? vdlr_pkg::WORD_WHITE : vdlr_pkg::WORD_RED;
    end
    if (cmd.step) begin
      la_r  <= AW'(32'(py) * 32'(DISPLAY_SIZE) + 32'(px));
      col_r <= col_r + CW'(1);
      if (acc_n > dx_r) begin
        row_r <= ydir_r ? row_r + CW'(1) : row_r - CW'(1);
        acc_r <= acc_n - (dx_r <<< 1);
      end else begin
        acc_r <= acc_n;
      end
    end
    fa_r <= sw_r;
    if (cmd.emit) begin
      out_read_data   <= (op_r == vdlr_pkg::OP_READ && rd_ok_r) ? q_r : '0;
      out_cursor_x    <= cur_x_r;
      out_cursor_y    <= cur_y_r;
      out_fade_active <= fade_r;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= mem[raddr];
    priority if (cmd.clear) mem[sw_r] <= '0;
    else if (fv_r) mem[fa_r] <= fade_word(q_r);
    else if (lw_r) mem[la_r] <= lword_r;
  end

endmodule

FILE: rtl/vector_display_line_rasterizer.sv
// Vector display line rasterizer. A command word is taken when start is high and busy is
// low; its single result word appears for one cycle with out_valid high, and the receiver
// must take it then. After reset the frame store is cleared, one pixel a cycle, with busy
// high. A drawing cursor move runs the Bresenham stepper, one pixel a cycle, along a line
// at most DISPLAY_SIZE pixels long. A tick with fade set sweeps the frame store through
// its single read-modify-write path. A pixel read goes through a registered frame-store
// read before its result word is emitted.
module vector_display_line_rasterizer #(
  parameter int DISPLAY_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_op,
  input  logic [15:0] in_x,
  input  logic [15:0] in_y,
  input  logic        in_colour_mode,
  input  logic [15:0] in_colour_value,
  input  logic        in_draw_enable,
  input  logic        in_fade_on,
  input  logic [15:0] in_pixel_addr,
  output logic        out_valid,
  output logic [31:0] out_read_data,
  output logic [15:0] out_cursor_x,
  output logic [15:0] out_cursor_y,
  output logic        out_fade_active
);

  vdlr_pkg::vdlr_cmd_t    cmd;
  vdlr_pkg::vdlr_status_t st;

  vdlr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_op     (in_op),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  vdlr_dp #(.DISPLAY_SIZE(DISPLAY_SIZE)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_op           (in_op),
    .in_x            (in_x),
    .in_y            (in_y),
    .in_colour_mode  (in_colour_mode),
    .in_colour_value (in_colour_value),
    .in_draw_enable  (in_draw_enable),
    .in_fade_on      (in_fade_on),
    .in_pixel_addr   (in_pixel_addr),
    .out_read_data   (out_read_data),
    .out_cursor_x    (out_cursor_x),
    .out_cursor_y    (out_cursor_y),
    .out_fade_active (out_fade_active)
  );

endmodule
